@@ hdl/lpag_pkg.sv @@
// Shared types and constants for the line pixel address generator.
`timescale 1ns / 1ps
`default_nettype none

package lpag_pkg;

    localparam int PIXEL_W  = 24;
    localparam int OFFSET_W = 24;
    localparam int STRIDE_W = 13;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd5760;

    // Input item opcodes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load;   // latch and order a new line
        logic step;   // form products for the current pixel, advance the stepper
        logic emit;   // move the finished pixel into the output register
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic line_active;
        logic out_free;
    } t_ctrl_status;

endpackage

`default_nettype wire

@@ hdl/lpag_item_if.sv @@
// Input channel: line load and pixel step requests.
`timescale 1ns / 1ps
`default_nettype none

interface lpag_item_if #(
    parameter int COORD_BITS = 11
);
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [COORD_BITS-1:0]         start_x;
    logic [COORD_BITS-1:0]         start_y;
    logic [COORD_BITS-1:0]         end_x;
    logic [COORD_BITS-1:0]         end_y;
    logic [lpag_pkg::PIXEL_W-1:0]  pixel_color;

    modport source (
        output valid, cmd, start_x, start_y, end_x, end_y, pixel_color,
        input  ready
    );
    modport sink (
        input  valid, cmd, start_x, start_y, end_x, end_y, pixel_color,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/lpag_pixel_if.sv @@
// Output channel: one pixel write per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface lpag_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [lpag_pkg::OFFSET_W-1:0] byte_offset;
    logic [lpag_pkg::PIXEL_W-1:0]  paint_color;
    logic                          last_pixel;

    modport source (
        output valid, byte_offset, paint_color, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, byte_offset, paint_color, last_pixel,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/lpag_cfg_if.sv @@
// Configuration write channel carrying the row stride.
`timescale 1ns / 1ps
`default_nettype none

interface lpag_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lpag_pkg::STRIDE_W-1:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/lpag_datapath.sv @@
// Datapath: line setup, remainder stepper, offset multiply and output register.
`timescale 1ns / 1ps
`default_nettype none

module lpag_datapath #(
    parameter int COORD_BITS      = 11,
    parameter int BYTES_PER_PIXEL = 3
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lpag_pkg::t_ctrl_cmd           i_cmd,
    output lpag_pkg::t_ctrl_status             o_status,
    input  wire logic [COORD_BITS-1:0]         i_start_x,
    input  wire logic [COORD_BITS-1:0]         i_start_y,
    input  wire logic [COORD_BITS-1:0]         i_end_x,
    input  wire logic [COORD_BITS-1:0]         i_end_y,
    input  wire logic [lpag_pkg::PIXEL_W-1:0]  i_pixel_color,
    input  wire logic                          i_cfg_wr,
    input  wire logic [lpag_pkg::STRIDE_W-1:0] i_cfg_data,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [lpag_pkg::OFFSET_W-1:0]      o_byte_offset,
    output logic [lpag_pkg::PIXEL_W-1:0]       o_paint_color,
    output logic                               o_last_pixel
);

    localparam int BPP_W     = $clog2(BYTES_PER_PIXEL + 1);
    localparam int COLP_W    = COORD_BITS + BPP_W;
    localparam int ROWP_W    = COORD_BITS + lpag_pkg::STRIDE_W;
    localparam int SUM_RAW_W = ROWP_W + 1;
    localparam int SUM_W     = (SUM_RAW_W > lpag_pkg::OFFSET_W) ? SUM_RAW_W
                                                                : lpag_pkg::OFFSET_W;
    localparam logic [BPP_W-1:0] C_BPP = BPP_W'(BYTES_PER_PIXEL);

    // Line state
    logic [lpag_pkg::STRIDE_W-1:0] r_stride;
    logic                          r_active;
    logic [COORD_BITS-1:0]         r_col;
    logic [COORD_BITS-1:0]         r_row;
    logic [COORD_BITS-1:0]         r_major;
    logic [COORD_BITS-1:0]         r_minor;
    logic [COORD_BITS-1:0]         r_rem;
    logic [COORD_BITS-1:0]         r_left;
    logic                          r_steep;
    logic                          r_neg;
    logic [lpag_pkg::PIXEL_W-1:0]  r_color;

    // Product stage
    logic [COLP_W-1:0]             r_col_prod;
    logic [ROWP_W-1:0]             r_row_prod;
    logic                          r_last_pend;

    // Output register
    logic                          r_out_valid;
    logic [lpag_pkg::OFFSET_W-1:0] r_out_offset;
    logic [lpag_pkg::PIXEL_W-1:0]  r_out_color;
    logic                          r_out_last;

    // Setup logic
    logic                  swap;
    logic [COORD_BITS-1:0] org_x, org_y, fin_x, fin_y;
    logic [COORD_BITS-1:0] dx, ady;
    logic                  dy_neg, steep;

    always_comb begin
        swap   = (i_start_x > i_end_x) || ((i_start_x == i_end_x) && (i_end_y < i_start_y));
        org_x  = swap ? i_end_x   : i_start_x;
        org_y  = swap ? i_end_y   : i_start_y;
        fin_x  = swap ? i_start_x : i_end_x;
        fin_y  = swap ? i_start_y : i_end_y;
        dx     = fin_x - org_x;
        dy_neg = fin_y < org_y;
        ady    = dy_neg ? (org_y - fin_y) : (fin_y - org_y);
        steep  = ady > dx;
    end

    // Remainder stepper: k*minor = q*major + rem, at most one carry per step
    logic [COORD_BITS:0]   rem_sum;
    logic                  carry;
    logic [COORD_BITS:0]   rem_sub;
    logic [COORD_BITS-1:0] row_adv;
    logic [COORD_BITS-1:0] col_adv;
    logic [SUM_W-1:0]      offset_sum;

    always_comb begin
        rem_sum    = {1'b0, r_rem} + {1'b0, r_minor};
        carry      = rem_sum >= {1'b0, r_major};
        rem_sub    = rem_sum - {1'b0, r_major};
        row_adv    = r_neg ? (r_row - COORD_BITS'(1)) : (r_row + COORD_BITS'(1));
        col_adv    = r_col + COORD_BITS'(1);
        offset_sum = SUM_W'(r_col_prod) + SUM_W'(r_row_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride    <= lpag_pkg::STRIDE_RESET;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_stride <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_active <= (steep ? ady : dx) != '0;
            end else if (i_cmd.step && (r_left == COORD_BITS'(1))) begin
                r_active <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col   <= org_x;
            r_row   <= org_y;
            r_major <= steep ? ady : dx;
            r_minor <= steep ? dx : ady;
            r_left  <= steep ? ady : dx;
            r_rem   <= '0;
            r_steep <= steep;
            r_neg   <= dy_neg;
            r_color <= i_pixel_color;
        end else if (i_cmd.step) begin
            r_col_prod  <= {{BPP_W{1'b0}}, r_col} * {{COORD_BITS{1'b0}}, C_BPP};
            r_row_prod  <= {{lpag_pkg::STRIDE_W{1'b0}}, r_row} *
                           {{COORD_BITS{1'b0}}, r_stride};
            r_last_pend <= r_left == COORD_BITS'(1);
            r_left      <= r_left - COORD_BITS'(1);
            r_rem       <= carry ? rem_sub[COORD_BITS-1:0] : rem_sum[COORD_BITS-1:0];
            if (r_steep) begin
                r_row <= row_adv;
                if (carry) begin
                    r_col <= col_adv;
                end
            end else begin
                r_col <= col_adv;
                if (carry) begin
                    r_row <= row_adv;
                end
            end
        end
        if (i_cmd.emit) begin
            r_out_offset <= offset_sum[lpag_pkg::OFFSET_W-1:0];
            r_out_color  <= r_color;
            r_out_last   <= r_last_pend;
        end
    end

    assign o_status.line_active = r_active;
    assign o_status.out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid          = r_out_valid;
    assign o_byte_offset        = r_out_offset;
    assign o_paint_color        = r_out_color;
    assign o_last_pixel         = r_out_last;

endmodule

`default_nettype wire

@@ hdl/lpag_controller.sv @@
// Controller: accepts input transactions and sequences each pixel step.
`timescale 1ns / 1ps
`default_nettype none

module lpag_controller (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_in_cmd,
    output logic                        o_in_ready,
    input  wire lpag_pkg::t_ctrl_status i_status,
    output lpag_pkg::t_ctrl_cmd         o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        accept     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                accept     = i_in_valid;
                if (accept && (i_in_cmd == lpag_pkg::CMD_LOAD)) begin
                    o_cmd.load = 1'b1;
                end else if (accept && i_status.line_active) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_EMIT;
                end
            end
            S_EMIT: begin
                // wait for the output register to drain
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ hdl/line_pixel_address_generator.sv @@
// Top level: line pixel address generator.
//
//  channel  | dir | payload                                       | handshake
//  ---------+-----+-----------------------------------------------+------------
//  i_in     | in  | cmd, start_x, start_y, end_x, end_y, pixel_col| valid/ready
//  o_out    | out | byte_offset, paint_color, last_pixel          | valid/ready
//  i_cfg    | in  | row stride (13 bits)                          | valid/ready
//
// A load transaction gives no result. A step transaction first does the offset
// multiply into the product registers, then the add into the output register;
// no new transaction is taken until that add is done.
// The output register lets the next transaction be taken while a pixel waits on o_out;
// a stall beyond that holds the step in its emit state. i_cfg is always ready.
// Synchronous active-low reset returns to idle with a stride of 5760.
`timescale 1ns / 1ps
`default_nettype none

module line_pixel_address_generator #(
    parameter int COORD_BITS      = 11,
    parameter int BYTES_PER_PIXEL = 3
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lpag_item_if.sink   i_in,
    lpag_pixel_if.source o_out,
    lpag_cfg_if.sink    i_cfg
);

    lpag_pkg::t_ctrl_cmd    ctrl_cmd;
    lpag_pkg::t_ctrl_status ctrl_status;

    assign i_cfg.ready = 1'b1;

    lpag_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (i_in.ready),
        .i_status   (ctrl_status),
        .o_cmd      (ctrl_cmd)
    );

    lpag_datapath #(
        .COORD_BITS      (COORD_BITS),
        .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctrl_cmd),
        .o_status      (ctrl_status),
        .i_start_x     (i_in.start_x),
        .i_start_y     (i_in.start_y),
        .i_end_x       (i_in.end_x),
        .i_end_y       (i_in.end_y),
        .i_pixel_color (i_in.pixel_color),
        .i_cfg_wr      (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_byte_offset (o_out.byte_offset),
        .o_paint_color (o_out.paint_color),
        .o_last_pixel  (o_out.last_pixel)
    );

endmodule

`default_nettype wire
